/* hdl/tsag_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsag_pkg
// Shared types and constants of the touch slot area gate.
// ----------------------------------------------------------------------------
package tsag_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned CountW = 4;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgAreaLeft   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAreaRight  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgAreaTop    = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgAreaBottom = 2'd3;

  typedef enum logic [1:0] {
    StIdle        = 2'd0,
    StPressed     = 2'd1,
    StMoved       = 2'd2,
    StUnsupported = 2'd3
  } slot_st_e;

  typedef enum logic [2:0] {
    EvCancel  = 3'd0,
    EvContact = 3'd1,
    EvLift    = 3'd2,
    EvSync    = 3'd3,
    EvKeysOff = 3'd4
  } ev_kind_e;

  // bit positions of the event plan, in emission order
  localparam int unsigned PlanCancel   = 0;
  localparam int unsigned PlanContact  = 1;
  localparam int unsigned PlanPressSync = 2;
  localparam int unsigned PlanLift     = 3;
  localparam int unsigned PlanKeysOff  = 4;
  localparam int unsigned PlanEndSync  = 5;
  localparam int unsigned PlanW        = 6;

  typedef struct packed {
    logic [PlanW-1:0]  mask;
    logic [SlotW-1:0]  slot;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } plan_t;

  localparam int unsigned PlanQDepth = 2;

endpackage

/* hdl/touch_slot_area_gate.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_slot_area_gate
// Multi-touch area gate: filters slot contacts through a configured rectangle.
// ----------------------------------------------------------------------------
// Each input item describes one touch slot of a frame. The front stage takes
// one item per clock while its plan queue has room, updates the slot status
// and active count in that same cycle, and records which events the item
// causes. The back stage turns each plan into events at one per clock while
// the result register is empty or being popped, so the events of an item leave
// one after another; items that cause no event write no plan and give none.
// The sustained rate is therefore set by the single result register: at most
// one event per clock. An accepted item's plan is registered in the plan queue,
// and its events are then registered in the result register. Area registers may
// be written at any time the block is idle; the write channel is always ready.
// ----------------------------------------------------------------------------
module touch_slot_area_gate import tsag_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // area configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CoordW-1:0]  cfg_data_i,
  // slot items
  input  logic               push,
  output logic               full,
  input  logic [SlotW-1:0]   slot_i,
  input  logic               present_now_i,
  input  logic               present_before_i,
  input  logic [CoordW-1:0]  pos_x_i,
  input  logic [CoordW-1:0]  pos_y_i,
  input  logic               cancel_request_i,
  input  logic               frame_end_i,
  // events
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         event_kind_o,
  output logic [SlotW-1:0]   event_slot_o,
  output logic [CoordW-1:0]  event_x_o,
  output logic [CoordW-1:0]  event_y_o,
  output logic               last_event_o
);

  logic  accept;
  logic  plan_wr, plan_full, plan_rd, plan_empty;
  plan_t plan_in, plan_out;

  // an item is taken whenever the plan queue can hold its plan
  assign full   = plan_full;
  assign accept = push && !plan_full;

  tsag_front #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .accept_i         (accept),
    .slot_i           (slot_i),
    .present_now_i    (present_now_i),
    .present_before_i (present_before_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .cancel_request_i (cancel_request_i),
    .frame_end_i      (frame_end_i),
    .plan_wr_o        (plan_wr),
    .plan_o           (plan_in)
  );

  // decouples slot bookkeeping from event delivery
  tsag_plan_fifo u_plan_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (plan_wr),
    .wr_data_i (plan_in),
    .full_o    (plan_full),
    .rd_i      (plan_rd),
    .rd_data_o (plan_out),
    .empty_o   (plan_empty)
  );

  tsag_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .plan_empty_i (plan_empty),
    .plan_i       (plan_out),
    .plan_rd_o    (plan_rd),
    .empty_o      (empty),
    .pop_i        (pop),
    .event_kind_o (event_kind_o),
    .event_slot_o (event_slot_o),
    .event_x_o    (event_x_o),
    .event_y_o    (event_y_o),
    .last_event_o (last_event_o)
  );

endmodule

/* hdl/tsag_plan_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsag_plan_fifo
// Two-entry queue of event plans between front and back.
// ----------------------------------------------------------------------------
module tsag_plan_fifo import tsag_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  plan_t wr_data_i,
  output logic  full_o,
  input  logic  rd_i,
  output plan_t rd_data_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = (PlanQDepth > 1) ? $clog2(PlanQDepth) : 1;
  localparam int unsigned CntW = $clog2(PlanQDepth + 1);

  plan_t             mem_q [PlanQDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(PlanQDepth));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(PlanQDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(PlanQDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

/* hdl/tsag_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsag_front
// Takes slot items, updates slot status and active count, builds event plans.
// ----------------------------------------------------------------------------
module tsag_front import tsag_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CoordW-1:0]    cfg_data_i,
  input  logic                 accept_i,
  input  logic [SlotW-1:0]     slot_i,
  input  logic                 present_now_i,
  input  logic                 present_before_i,
  input  logic [CoordW-1:0]    pos_x_i,
  input  logic [CoordW-1:0]    pos_y_i,
  input  logic                 cancel_request_i,
  input  logic                 frame_end_i,
  output logic                 plan_wr_o,
  output plan_t                plan_o
);

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [CoordW-1:0] left_q, right_q, top_q, bottom_q;
  slot_st_e          status_q [SLOT_COUNT];
  logic [CountW-1:0] count_q, count_d;

  logic              in_range, in_area;
  logic [IdxW-1:0]   idx;
  slot_st_e          st_old, st_new;
  logic              cnt_inc, cnt_dec;
  logic [CountW-1:0] count_inc;
  logic [PlanW-1:0]  mask;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      right_q  <= '1;
      top_q    <= '0;
      bottom_q <= '1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgAreaLeft:   left_q   <= cfg_data_i;
        CfgAreaRight:  right_q  <= cfg_data_i;
        CfgAreaTop:    top_q    <= cfg_data_i;
        CfgAreaBottom: bottom_q <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  assign in_range = ({1'b0, slot_i} < (SlotW + 1)'(SLOT_COUNT));
  assign idx      = slot_i[IdxW-1:0];
  assign in_area  = (pos_x_i >= left_q) && (pos_x_i <= right_q) &&
                    (pos_y_i >= top_q) && (pos_y_i <= bottom_q);
  assign st_old   = in_range ? status_q[idx] : StIdle;

  // slot transition and the slot events it gives
  always_comb begin
    slot_st_e st;
    st      = st_old;
    cnt_inc = 1'b0;
    cnt_dec = 1'b0;
    mask    = '0;
    mask[PlanCancel] = cancel_request_i;
    if (in_range) begin
      if (present_now_i) begin
        if (!present_before_i) begin
          if (!in_area) begin
            st = StUnsupported;
          end else begin
            st      = StPressed;
            cnt_inc = 1'b1;
          end
        end
        if (st == StPressed || st == StMoved) begin
          if (!in_area) begin
            mask[PlanLift] = 1'b1;
            st      = StIdle;
            cnt_dec = 1'b1;
          end else begin
            mask[PlanContact] = 1'b1;
            if (st == StPressed) begin
              mask[PlanPressSync] = 1'b1;
              st = StMoved;
            end
          end
        end
      end else if (present_before_i) begin
        if (in_area && st == StMoved) begin
          mask[PlanLift] = 1'b1;
          st      = StIdle;
          cnt_dec = 1'b1;
        end
      end
    end
    st_new = st;
  end

  // count saturates high and floors at zero
  always_comb begin
    count_inc = (cnt_inc && count_q != '1) ? count_q + 1'b1 : count_q;
    count_d   = (cnt_dec && count_inc != '0) ? count_inc - 1'b1 : count_inc;
  end

  always_comb begin
    plan_o      = '0;
    plan_o.mask = mask;
    plan_o.mask[PlanKeysOff] = frame_end_i && (count_d == '0);
    plan_o.mask[PlanEndSync] = frame_end_i;
    plan_o.slot = slot_i;
    plan_o.x    = pos_x_i;
    plan_o.y    = pos_y_i;
  end

  assign plan_wr_o = accept_i && (plan_o.mask != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        status_q[i] <= StIdle;
      end
    end else if (accept_i) begin
      count_q <= count_d;
      if (in_range) begin
        status_q[idx] <= st_new;
      end
    end
  end

endmodule

/* hdl/tsag_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsag_back
// Walks each plan, issuing one event per cycle when the result register is free.
// ----------------------------------------------------------------------------
module tsag_back import tsag_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              plan_empty_i,
  input  plan_t             plan_i,
  output logic              plan_rd_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [2:0]        event_kind_o,
  output logic [SlotW-1:0]  event_slot_o,
  output logic [CoordW-1:0] event_x_o,
  output logic [CoordW-1:0] event_y_o,
  output logic              last_event_o
);

  logic [PlanW-1:0]  done_q, done_d;
  logic [PlanW-1:0]  remaining, sel;
  logic              is_last, issue;
  logic              valid_q, valid_d;
  ev_kind_e          kind_q, kind_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [CoordW-1:0] x_q, x_d, y_q, y_d;
  logic              last_q, last_d;

  assign remaining = plan_empty_i ? '0 : (plan_i.mask & ~done_q);
  assign sel       = remaining & (~remaining + 1'b1);
  assign is_last   = ((remaining & ~sel) == '0);
  assign issue     = (remaining != '0) && (!valid_q || pop_i);
  assign plan_rd_o = issue && is_last;

  always_comb begin
    done_d = done_q;
    if (issue) begin
      done_d = is_last ? '0 : (done_q | sel);
    end
  end

  always_comb begin
    kind_d = EvSync;
    slot_d = '0;
    x_d    = '0;
    y_d    = '0;
    last_d = is_last;
    priority if (sel[PlanCancel]) begin
      kind_d = EvCancel;
    end else if (sel[PlanContact]) begin
      kind_d = EvContact;
      slot_d = plan_i.slot;
      x_d    = plan_i.x;
      y_d    = plan_i.y;
    end else if (sel[PlanLift]) begin
      kind_d = EvLift;
      slot_d = plan_i.slot;
    end else if (sel[PlanKeysOff]) begin
      kind_d = EvKeysOff;
    end else begin
      kind_d = EvSync;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (issue) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      done_q  <= done_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      kind_q <= kind_d;
      slot_q <= slot_d;
      x_q    <= x_d;
      y_q    <= y_d;
      last_q <= last_d;
    end
  end

  assign empty_o      = !valid_q;
  assign event_kind_o = kind_q;
  assign event_slot_o = slot_q;
  assign event_x_o    = x_q;
  assign event_y_o    = y_q;
  assign last_event_o = last_q;

endmodule
